// ----- src/ooe_pkg.sv -----
// Shared types and constants for the octahedral orbit expander.
// No dependencies.
package ooe_pkg;
   localparam int FRAC = 30;
   localparam logic [30:0] ONE = 31'h4000_0000;
   localparam logic [2:0] CLS_AXIS = 3'd1, CLS_EDGE = 3'd2, CLS_CORNER = 3'd3,
      CLS_AAB = 3'd4, CLS_AB0 = 3'd5, CLS_ABC = 3'd6;

   // queued work descriptor from front to back
   typedef struct packed {
      logic [2:0]  cls;
      logic [30:0] a;
      logic [30:0] b;
      logic [30:0] c;
      logic [31:0] w;
   } job_type;

   function automatic logic [5:0] point_count(input logic [2:0] cls);
      logic [5:0] n;
      case (cls)
         CLS_AXIS:   n = 6'd6;
         CLS_EDGE:   n = 6'd12;
         CLS_CORNER: n = 6'd8;
         CLS_AAB:    n = 6'd24;
         CLS_AB0:    n = 6'd24;
         CLS_ABC:    n = 6'd48;
         default:    n = 6'd1;
      endcase
      return n;
   endfunction
endpackage

// ----- src/ooe_front.sv -----
// Front part: accepts descriptors and computes the third coordinate bit by bit.
// Depends on ooe_pkg.
module ooe_front import ooe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_orbit_class,
   input  logic [30:0] req_param_a,
   input  logic [30:0] req_param_b,
   input  logic [31:0] req_point_weight,
   output logic        job_valid,
   input  logic        job_full,
   output job_type     job
);
   typedef enum logic [1:0] {S_IDLE, S_SQ, S_ROOT, S_PUSH} state_type;
   state_type   state_ff;
   job_type     job_ff;
   logic [4:0]  bit_ff;
   logic [1:0]  k_ff;
   logic [63:0] extra_ff;
   logic [30:0] t_w;
   logic [63:0] lhs_w;

   assign req_stall = (state_ff != S_IDLE);
   assign job_valid = (state_ff == S_PUSH);
   assign job = job_ff;

   // trial square of the candidate bit, one per cycle
   assign t_w = job_ff.c | (31'd1 << bit_ff);
   always_comb begin
      logic [61:0] tt;
      tt = t_w[30:0] * t_w[30:0];
      lhs_w = extra_ff + ({2'b0, tt} * k_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) begin
               job_ff.cls <= req_orbit_class;
               job_ff.a <= req_param_a;
               job_ff.b <= req_param_b;
               job_ff.w <= req_point_weight;
               job_ff.c <= '0;
               bit_ff <= 5'(FRAC);
               case (req_orbit_class)
                  CLS_EDGE:   k_ff <= 2'd2;
                  CLS_CORNER: k_ff <= 2'd3;
                  default:    k_ff <= 2'd1;
               endcase
               state_ff <= S_SQ;
            end
            S_SQ: begin
               // form the radicand offset a^2, 2a^2 or a^2+b^2
               case (job_ff.cls)
                  CLS_AAB: extra_ff <= {1'b0, 62'(job_ff.a) * 62'(job_ff.a), 1'b0};
                  CLS_AB0: extra_ff <= {2'b0, 62'(job_ff.a) * 62'(job_ff.a)};
                  CLS_ABC: extra_ff <= {2'b0, 62'(job_ff.a) * 62'(job_ff.a)} +
                                       {2'b0, 62'(job_ff.b) * 62'(job_ff.b)};
                  default: extra_ff <= '0;
               endcase
               state_ff <= (job_ff.cls inside {CLS_EDGE, CLS_CORNER, CLS_AAB, CLS_AB0,
                  CLS_ABC}) ? S_ROOT : S_PUSH;
            end
            S_ROOT: begin
               if (t_w <= ONE && lhs_w <= 64'h1000_0000_0000_0000) job_ff.c <= t_w;
               if (bit_ff == 5'd0) state_ff <= S_PUSH;
               else bit_ff <= bit_ff - 5'd1;
            end
            S_PUSH: if (!job_full) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_push_after_root: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> !req_stall || state_ff == S_PUSH) else $error("push state");
   a_c_bounded: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> job_ff.c <= ONE) else $error("root above one");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      $past(req_valid && !req_stall && !reset) |-> req_stall)
      else $error("accept while busy");
endmodule

// ----- src/ooe_queue.sv -----
// Two-entry queue between front and back.
// Depends on ooe_pkg.
module ooe_queue import ooe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    nonempty,
   output job_type head
);
   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   assign full = (cnt_ff == 2'd2);
   assign nonempty = (cnt_ff != 2'd0);
   assign head = mem_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push && !full) begin
            mem_ff[wp_ff] <= push_job;
            wp_ff <= ~wp_ff;
         end
         if (pop && nonempty) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push && !full) - 2'(pop && nonempty);
      end
   end
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wp_ff == rp_ff) else $error("pointers");
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      full && !pop |=> full) else $error("lost entry");
endmodule

// ----- src/ooe_back.sv -----
// Back part: walks the points of one orbit and drives the result register.
// Depends on ooe_pkg.
module ooe_back import ooe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_ready,
   input  job_type     job,
   output logic        job_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_dir_x,
   output logic [31:0] rsp_dir_y,
   output logic [31:0] rsp_dir_z,
   output logic [31:0] rsp_dir_weight,
   output logic        rsp_bad_class,
   output logic        rsp_run_end
);
   logic [5:0]  step_ff;
   logic [2:0]  perm_ff, sign_ff;
   logic        val_ff;
   logic [31:0] x_ff, y_ff, z_ff, w_ff;
   logic        bad_ff, end_ff;
   logic        load_w;
   logic [31:0] x_w, y_w, z_w;
   logic [5:0]  n_w;
   logic [2:0]  perm_last_w;
   logic        bad_w;

   assign load_w = job_ready && (!val_ff || !rsp_stall);
   assign n_w = point_count(job.cls);
   assign job_pop = load_w && (step_ff == n_w - 6'd1);
   assign bad_w = (n_w == 6'd1);

   // last permutation index within one sign combination
   always_comb begin
      case (job.cls)
         CLS_AXIS, CLS_EDGE, CLS_AAB: perm_last_w = 3'd2;
         CLS_AB0, CLS_ABC:            perm_last_w = 3'd5;
         default:                     perm_last_w = 3'd0;
      endcase
   end

   function automatic logic [31:0] sg(input logic n, input logic [30:0] m);
      return n ? 32'd0 - {1'b0, m} : {1'b0, m};
   endfunction

   always_comb begin
      logic [2:0] s;
      logic [2:0] p;
      logic [30:0] a, b, c;
      a = job.a; b = job.b; c = job.c;
      s = sign_ff; p = perm_ff;
      x_w = '0; y_w = '0; z_w = '0;
      case (job.cls)
         CLS_AXIS: begin
            case (p)
               3'd0: x_w = sg(s[0], ONE);
               3'd1: y_w = sg(s[0], ONE);
               default: z_w = sg(s[0], ONE);
            endcase
         end
         CLS_EDGE: begin
            case (p)
               3'd0: begin y_w = sg(s[1], c); z_w = sg(s[0], c); end
               3'd1: begin x_w = sg(s[1], c); z_w = sg(s[0], c); end
               default: begin x_w = sg(s[1], c); y_w = sg(s[0], c); end
            endcase
         end
         CLS_CORNER: begin
            x_w = sg(step_ff[2], c); y_w = sg(step_ff[1], c); z_w = sg(step_ff[0], c);
         end
         CLS_AAB: begin
            case (p)
               3'd0: begin x_w = sg(s[2], a); y_w = sg(s[1], a); z_w = sg(s[0], c); end
               3'd1: begin x_w = sg(s[2], a); y_w = sg(s[1], c); z_w = sg(s[0], a); end
               default: begin x_w = sg(s[2], c); y_w = sg(s[1], a); z_w = sg(s[0], a); end
            endcase
         end
         CLS_AB0: begin
            case (p)
               3'd0: begin x_w = sg(s[1], a); y_w = sg(s[0], c); end
               3'd1: begin x_w = sg(s[1], c); y_w = sg(s[0], a); end
               3'd2: begin x_w = sg(s[1], a); z_w = sg(s[0], c); end
               3'd3: begin x_w = sg(s[1], c); z_w = sg(s[0], a); end
               3'd4: begin y_w = sg(s[1], a); z_w = sg(s[0], c); end
               default: begin y_w = sg(s[1], c); z_w = sg(s[0], a); end
            endcase
         end
         CLS_ABC: begin
            case (p)
               3'd0: begin x_w = sg(s[2], a); y_w = sg(s[1], b); z_w = sg(s[0], c); end
               3'd1: begin x_w = sg(s[2], b); y_w = sg(s[1], a); z_w = sg(s[0], c); end
               3'd2: begin x_w = sg(s[2], a); y_w = sg(s[1], c); z_w = sg(s[0], b); end
               3'd3: begin x_w = sg(s[2], c); y_w = sg(s[1], a); z_w = sg(s[0], b); end
               3'd4: begin x_w = sg(s[2], b); y_w = sg(s[1], c); z_w = sg(s[0], a); end
               default: begin x_w = sg(s[2], c); y_w = sg(s[1], b); z_w = sg(s[0], a); end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         perm_ff <= '0;
         sign_ff <= '0;
         val_ff <= 1'b0;
      end else begin
         if (load_w) begin
            val_ff <= 1'b1;
            if (job_pop) begin
               step_ff <= 6'd0;
               perm_ff <= 3'd0;
               sign_ff <= 3'd0;
            end else begin
               step_ff <= step_ff + 6'd1;
               // advance the permutation, carry into the sign pattern
               if (perm_ff == perm_last_w) begin
                  perm_ff <= 3'd0;
                  sign_ff <= sign_ff + 3'd1;
               end else begin
                  perm_ff <= perm_ff + 3'd1;
               end
            end
         end else if (!rsp_stall) begin
            val_ff <= 1'b0;
         end
      end
      if (load_w) begin
         x_ff <= x_w; y_ff <= y_w; z_ff <= z_w;
         w_ff <= bad_w ? 32'd0 : job.w;
         bad_ff <= bad_w;
         end_ff <= job_pop;
      end
   end

   assign rsp_valid = val_ff;
   assign rsp_dir_x = x_ff;
   assign rsp_dir_y = y_ff;
   assign rsp_dir_z = z_ff;
   assign rsp_dir_weight = w_ff;
   assign rsp_bad_class = bad_ff;
   assign rsp_run_end = end_ff;

   a_bad_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_class |-> rsp_run_end) else $error("bad without end");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dir_x)) else $error("hold");
   a_step: assert property (@(posedge clock) disable iff (reset) step_ff < 6'd48)
      else $error("step range");
endmodule

// ----- src/octahedral_orbit_expander_unit.sv -----
// Top level of the octahedral orbit expander.
// Depends on ooe_pkg, ooe_front, ooe_queue, ooe_back.
//
// Each accepted item (class, a, b, weight) expands to 6, 12, 8, 24, 24 or 48
// result items, one per cycle when the output is not stalled; an invalid class
// gives one flagged item. The front takes an item, squares the parameters,
// runs a one-bit-per-cycle square root for every valid class but the axis one,
// and pushes the job into a two-entry queue, waiting while the queue is full;
// the back emits the points from the queue head. The front takes no new item
// until it has pushed the current job, so the sustained rate is set by the
// slower of the front's work per item and the back's emission of the points.
module octahedral_orbit_expander_unit import ooe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_orbit_class,
   input  logic [30:0] req_param_a,
   input  logic [30:0] req_param_b,
   input  logic [31:0] req_point_weight,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_dir_x,
   output logic [31:0] rsp_dir_y,
   output logic [31:0] rsp_dir_z,
   output logic [31:0] rsp_dir_weight,
   output logic        rsp_bad_class,
   output logic        rsp_run_end
);
   job_type push_job, head_job;
   logic    push, full, pop, nonempty;

   ooe_front u_front (.clock, .reset, .req_valid, .req_stall, .req_orbit_class,
      .req_param_a, .req_param_b, .req_point_weight,
      .job_valid(push), .job_full(full), .job(push_job));
   ooe_queue u_queue (.clock, .reset, .push, .push_job, .full, .pop, .nonempty,
      .head(head_job));
   ooe_back u_back (.clock, .reset, .job_ready(nonempty), .job(head_job),
      .job_pop(pop), .rsp_valid, .rsp_stall, .rsp_dir_x, .rsp_dir_y, .rsp_dir_z,
      .rsp_dir_weight, .rsp_bad_class, .rsp_run_end);
endmodule
